// ----- hw/rtl/imuo_pkg.sv -----
// Package for the IMU-aided odometry integrator.
// Holds the request payload types and the fixed constants of the datapath.
// No dependencies; compile this file first.
package imuo_pkg;

	// Operation codes of an input request.
	localparam logic OP_IMU  = 1'b0;
	localparam logic OP_ODOM = 1'b1;

	// Reset value of the yaw rate threshold register (0.01 in Q16.16).
	localparam logic [15:0] THR_RESET = 16'd655;

	// Widths of the shared multiply-accumulate unit.
	localparam int AW   = 42;
	localparam int BW   = 17;
	localparam int PW   = AW + BW;
	localparam int ACCW = 96;

	// Displacement magnitude clamp, 2^50.
	localparam logic [75:0] DISP_CLAMP = 76'd1 << 50;

	typedef struct packed {
		logic              operation;
		logic signed [31:0] odom_lin_x;
		logic signed [31:0] odom_lin_y;
		logic signed [31:0] odom_lin_z;
		logic signed [31:0] odom_yaw_rate;
		logic        [47:0] odom_stamp;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [31:0] gyro_yaw_rate;
	} in_item_t;

	typedef struct packed {
		logic signed [47:0] pos_x;
		logic signed [47:0] pos_y;
		logic signed [47:0] pos_z;
		logic signed [31:0] corrected_lin_x;
	} out_item_t;

endpackage

// ----- hw/rtl/imuo_if.sv -----
// Valid/ready channel interfaces for the odometry integrator.
// Depends on imuo_pkg for the payload types.
interface imuo_in_if;
	logic               valid;
	logic               ready;
	imuo_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface imuo_out_if;
	logic                valid;
	logic                ready;
	imuo_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/imu_aided_odometry_integrator_unit.sv -----
// Top level of the IMU-aided odometry integrator: slip correction, quaternion
// rotation and position integration on one shared multiply-accumulate unit.
// Depends on imuo_pkg and the channel interfaces in imuo_if.sv.
//
// Channel   Direction  Handshake        Payload
// in_ch     sink       valid / ready    imuo_pkg::in_item_t
// out_ch    source     valid / ready    imuo_pkg::out_item_t
// cfg       write      cfg_we           cfg_wdata, yaw rate threshold
//
// An IMU request only loads the quaternion and gyro registers; an odometry
// request runs S_SMUL, S_SABS, S_DIV and S_SFIN when slip correction runs,
// then S_CROSS, S_ROT, S_DISP and S_DONE; the result turns valid as the block
// turns ready again. Slip correction adds the 64-step restoring divider; the
// rest is 24 steps of the shared 42x17 multiplier (26 with correction). The
// block takes one request at a time; in_ch.ready is high only when idle. A
// finished result waits in the output register; a stalled output delays the
// final step only. Reset clears FSM and positions, loads the threshold to 655.
module imu_aided_odometry_integrator_unit (
	input  logic               clk,
	input  logic               arst_n,
	imuo_in_if.sink            in_ch,
	imuo_out_if.source         out_ch,
	input  logic               cfg_we,
	input  logic        [15:0] cfg_wdata
);

	localparam int ACCW_L = imuo_pkg::ACCW;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SMUL  = 9'b000000010,
		S_SABS  = 9'b000000100,
		S_DIV   = 9'b000001000,
		S_SFIN  = 9'b000010000,
		S_CROSS = 9'b000100000,
		S_ROT   = 9'b001000000,
		S_DISP  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [1:0] comp_q;
	logic [1:0] stp_q;
	logic [5:0] dcnt_q;
	logic [15:0] thr_q;

	logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
	logic signed [31:0] gyro_q;
	logic signed [31:0] v0_q, v1_q, v2_q;
	logic signed [35:0] t0_q, t1_q, t2_q;
	logic signed [41:0] r0_q, r1_q, r2_q;
	logic signed [47:0] pos0_q, pos1_q, pos2_q;
	logic [47:0] prev_q, stamp_q, dtmag_q;
	logic        dneg_q;
	logic [31:0] ymag_q;
	logic        yneg_q;
	logic        qneg_q;
	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [ACCW_L-1:0] acc_q;
	logic        out_valid_q;
	imuo_pkg::out_item_t out_q;

	// Request decode at the input.
	logic accept;
	logic [48:0] dt49;
	logic [48:0] dtabs;
	logic [32:0] y33;
	logic [32:0] yabs;
	logic        slip_on;

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept = in_ch.valid && in_ch.ready;
	assign dt49 = {1'b0, in_ch.data.odom_stamp} - {1'b0, prev_q};
	assign dtabs = dt49[48] ? (49'd0 - dt49) : dt49;
	assign y33 = {in_ch.data.odom_yaw_rate[31], in_ch.data.odom_yaw_rate};
	assign yabs = y33[32] ? (33'd0 - y33) : y33;
	assign slip_on = (yabs[31:0] > {16'd0, thr_q}) && (in_ch.data.odom_yaw_rate != 32'sd0);

	// Operand selection for the shared multiply-accumulate unit.
	logic signed [imuo_pkg::AW-1:0] a_op;
	logic signed [imuo_pkg::BW-1:0] b_op;
	logic signed [imuo_pkg::PW-1:0] prod;
	logic mac_en, clr, shl, sub;
	logic signed [41:0] r_sel;
	logic [41:0] rmag;

	always_comb begin
		case (comp_q)
			2'd0: r_sel = r0_q;
			2'd1: r_sel = r1_q;
			default: r_sel = r2_q;
		endcase
		rmag = r_sel[41] ? (42'd0 - r_sel) : r_sel;
	end

	function automatic logic signed [41:0] sx32(input logic signed [31:0] x);
		sx32 = {{10{x[31]}}, x};
	endfunction

	function automatic logic signed [41:0] sx36(input logic signed [35:0] x);
		sx36 = {{6{x[35]}}, x};
	endfunction

	function automatic logic signed [16:0] sx16(input logic signed [15:0] x);
		sx16 = {x[15], x};
	endfunction

	always_comb begin
		a_op = '0;
		b_op = '0;
		mac_en = 1'b0;
		clr = 1'b0;
		shl = 1'b0;
		sub = 1'b0;
		case (state_q)
			S_SMUL: begin
				mac_en = 1'b1;
				a_op = sx32(v0_q);
				if (stp_q == 2'd0) begin
					b_op = sx16(gyro_q[31:16]);
					clr = 1'b1;
				end else begin
					b_op = {1'b0, gyro_q[15:0]};
					shl = 1'b1;
				end
			end
			S_CROSS: begin
				mac_en = 1'b1;
				clr = (stp_q == 2'd0);
				sub = (stp_q == 2'd1);
				case ({comp_q, stp_q[0]})
					3'b000: begin a_op = sx32(v2_q); b_op = sx16(qy_q); end
					3'b001: begin a_op = sx32(v1_q); b_op = sx16(qz_q); end
					3'b010: begin a_op = sx32(v0_q); b_op = sx16(qz_q); end
					3'b011: begin a_op = sx32(v2_q); b_op = sx16(qx_q); end
					3'b100: begin a_op = sx32(v1_q); b_op = sx16(qx_q); end
					default: begin a_op = sx32(v0_q); b_op = sx16(qy_q); end
				endcase
			end
			S_ROT: begin
				mac_en = 1'b1;
				clr = (stp_q == 2'd0);
				sub = (stp_q == 2'd2);
				if (stp_q == 2'd0) begin
					b_op = sx16(qw_q);
					case (comp_q)
						2'd0: a_op = sx36(t0_q);
						2'd1: a_op = sx36(t1_q);
						default: a_op = sx36(t2_q);
					endcase
				end else begin
					case ({comp_q, stp_q[1]})
						3'b000: begin a_op = sx36(t2_q); b_op = sx16(qy_q); end
						3'b001: begin a_op = sx36(t1_q); b_op = sx16(qz_q); end
						3'b010: begin a_op = sx36(t0_q); b_op = sx16(qz_q); end
						3'b011: begin a_op = sx36(t2_q); b_op = sx16(qx_q); end
						3'b100: begin a_op = sx36(t1_q); b_op = sx16(qx_q); end
						default: begin a_op = sx36(t0_q); b_op = sx16(qy_q); end
					endcase
				end
			end
			S_DISP: begin
				mac_en = (stp_q != 2'd3);
				a_op = rmag;
				case (stp_q)
					2'd0: begin b_op = {1'b0, dtmag_q[47:32]}; clr = 1'b1; end
					2'd1: begin b_op = {1'b0, dtmag_q[31:16]}; shl = 1'b1; end
					default: begin b_op = {1'b0, dtmag_q[15:0]}; shl = 1'b1; end
				endcase
			end
			default: begin
				mac_en = 1'b0;
			end
		endcase
	end

	// Shared multiplier and accumulator adder.
	logic [ACCW_L-1:0] prod_ext, acc_base, acc_d;

	assign prod = a_op * b_op;
	assign prod_ext = {{(ACCW_L - imuo_pkg::PW){prod[imuo_pkg::PW-1]}}, prod};
	assign acc_base = clr ? '0 : (shl ? {acc_q[ACCW_L-17:0], 16'h0000} : acc_q);
	assign acc_d = sub ? (acc_base - prod_ext) : (acc_base + prod_ext);

	// Restoring divider step: one quotient bit per cycle.
	logic [32:0] rs;
	logic [33:0] diff;
	logic        ge;

	assign rs = {rem_q, quo_q[63]};
	assign diff = {1'b0, rs} - {2'b00, ymag_q};
	assign ge = !diff[33];

	// Saturated slip-corrected speed.
	logic [31:0] v0_sat;

	always_comb begin
		if (qneg_q) begin
			v0_sat = (quo_q > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - quo_q[31:0]);
		end else begin
			v0_sat = (quo_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_q[31:0];
		end
	end

	// Rotated velocity component, built from v and the cross products t.
	logic signed [41:0] r_new;
	logic signed [41:0] v_sel;

	always_comb begin
		case (comp_q)
			2'd0: v_sel = sx32(v0_q);
			2'd1: v_sel = sx32(v1_q);
			default: v_sel = sx32(v2_q);
		endcase
		r_new = v_sel + $signed(acc_d[55:14]);
	end

	// Displacement clamp and saturating position update.
	logic [75:0] dfull;
	logic [50:0] dmag;
	logic [52:0] dsig, psum;
	logic signed [47:0] pos_sel;
	logic [47:0] pos_new;

	always_comb begin
		case (comp_q)
			2'd0: pos_sel = pos0_q;
			2'd1: pos_sel = pos1_q;
			default: pos_sel = pos2_q;
		endcase
		dfull = acc_q[95:20];
		dmag = (dfull > imuo_pkg::DISP_CLAMP) ? imuo_pkg::DISP_CLAMP[50:0] : dfull[50:0];
		dsig = (dneg_q ^ r_sel[41]) ? (53'd0 - {2'b00, dmag}) : {2'b00, dmag};
		psum = {{5{pos_sel[47]}}, pos_sel} + dsig;
		if (psum[52:47] != {6{psum[52]}}) begin
			pos_new = psum[52] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		end else begin
			pos_new = psum[47:0];
		end
	end

	// Result handover into the output register.
	logic load_out;

	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= imuo_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			comp_q <= '0;
			stp_q <= '0;
			dcnt_q <= '0;
			qw_q <= '0;
			qx_q <= '0;
			qy_q <= '0;
			qz_q <= '0;
			gyro_q <= '0;
			pos0_q <= '0;
			pos1_q <= '0;
			pos2_q <= '0;
			prev_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (mac_en) begin
				acc_q <= acc_d;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					comp_q <= '0;
					stp_q <= '0;
					if (accept) begin
						if (in_ch.data.operation == imuo_pkg::OP_IMU) begin
							qw_q <= in_ch.data.quat_w;
							qx_q <= in_ch.data.quat_x;
							qy_q <= in_ch.data.quat_y;
							qz_q <= in_ch.data.quat_z;
							gyro_q <= in_ch.data.gyro_yaw_rate;
						end else begin
							v0_q <= in_ch.data.odom_lin_x;
							v1_q <= in_ch.data.odom_lin_y;
							v2_q <= in_ch.data.odom_lin_z;
							ymag_q <= yabs[31:0];
							yneg_q <= y33[32];
							stamp_q <= in_ch.data.odom_stamp;
							dtmag_q <= dtabs[47:0];
							dneg_q <= dt49[48];
							state_q <= slip_on ? S_SMUL : S_CROSS;
						end
					end
				end
				S_SMUL: begin
					if (stp_q == 2'd0) begin
						stp_q <= 2'd1;
					end else begin
						stp_q <= '0;
						state_q <= S_SABS;
					end
				end
				S_SABS: begin
					quo_q <= acc_q[63] ? (64'd0 - acc_q[63:0]) : acc_q[63:0];
					qneg_q <= acc_q[63] ^ yneg_q;
					rem_q <= '0;
					dcnt_q <= 6'd63;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= ge ? diff[31:0] : rs[31:0];
					quo_q <= {quo_q[62:0], ge};
					dcnt_q <= dcnt_q - 6'd1;
					if (dcnt_q == 6'd0) begin
						state_q <= S_SFIN;
					end
				end
				S_SFIN: begin
					v0_q <= v0_sat;
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					if (stp_q == 2'd0) begin
						stp_q <= 2'd1;
					end else begin
						stp_q <= '0;
						case (comp_q)
							2'd0: t0_q <= acc_d[48:13];
							2'd1: t1_q <= acc_d[48:13];
							default: t2_q <= acc_d[48:13];
						endcase
						if (comp_q == 2'd2) begin
							comp_q <= '0;
							state_q <= S_ROT;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end
				end
				S_ROT: begin
					if (stp_q != 2'd2) begin
						stp_q <= stp_q + 2'd1;
					end else begin
						stp_q <= '0;
						case (comp_q)
							2'd0: r0_q <= r_new;
							2'd1: r1_q <= r_new;
							default: r2_q <= r_new;
						endcase
						if (comp_q == 2'd2) begin
							comp_q <= '0;
							state_q <= S_DISP;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end
				end
				S_DISP: begin
					if (stp_q != 2'd3) begin
						stp_q <= stp_q + 2'd1;
					end else begin
						stp_q <= '0;
						case (comp_q)
							2'd0: pos0_q <= pos_new;
							2'd1: pos1_q <= pos_new;
							default: pos2_q <= pos_new;
						endcase
						if (comp_q == 2'd2) begin
							comp_q <= '0;
							prev_q <= stamp_q;
							state_q <= S_DONE;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register, loaded when the result is handed over.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.pos_x <= pos0_q;
			out_q.pos_y <= pos1_q;
			out_q.pos_z <= pos2_q;
			out_q.corrected_lin_x <= v0_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

endmodule
